/* src/utf8_name_validator_assert.svh */
// Assertion macros for the UTF-8 name validator checker.
// Included by the checker file; needs no package.
`ifndef UTF8_NAME_VALIDATOR_ASSERT_SVH
`define UTF8_NAME_VALIDATOR_ASSERT_SVH

// Property checked only out of reset
`define UTF8NV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included
`define UTF8NV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/utf8nv_pkg.sv */
// Shared types, constants and the allowed-character test for the UTF-8
// name validator. No dependencies.
package utf8nv_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned LEN_W = 6;

  localparam logic [CNT_W-1:0] CNT_CAP = 7'd64;
  localparam logic [LEN_W-1:0] LEN_RST = 6'd32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_UTF8 = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_CHAR = 2'd3
  } status_t;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } item_t;

  // Input stage to decoder: item handed over this cycle
  typedef struct packed {
    logic  fire;
    item_t item;
  } step_t;

  // Decoder to result register
  typedef struct packed {
    logic             load;
    status_t          status;
    logic [CNT_W-1:0] count;
  } verdict_t;

  // Letters, digits, '_', '-' and the CJK blocks
  function automatic logic allowed_point(input logic [CP_W-1:0] c);
    logic ok;
    ok = ((c >= 21'h61)    && (c <= 21'h7A))    ||
         ((c >= 21'h41)    && (c <= 21'h5A))    ||
         ((c >= 21'h30)    && (c <= 21'h39))    ||
         (c == 21'h5F) || (c == 21'h2D)         ||
         ((c >= 21'h3400)  && (c <= 21'h4DBF))  ||
         ((c >= 21'h4E00)  && (c <= 21'h9FFF))  ||
         ((c >= 21'hF900)  && (c <= 21'hFAFF))  ||
         ((c >= 21'h20000) && (c <= 21'h2A6DF)) ||
         ((c >= 21'h2A700) && (c <= 21'h2CEAF));
    return ok;
  endfunction

endpackage

/* src/utf8nv_if.sv */
// Valid/ready channel interfaces for the UTF-8 name validator.
// Depends on nothing; payload widths follow the field list.
interface utf8nv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface utf8nv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] codepoint_count;

  modport source (output valid, status, codepoint_count, input ready);
  modport sink   (input valid, status, codepoint_count, output ready);
endinterface

/* src/utf8nv_in_reg.sv */
// Input register stage: holds one byte beat and hands it to the decoder.
// Depends on utf8nv_pkg.
module utf8nv_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf8nv_pkg::item_t    in_item,
  input  logic                 out_free,
  output utf8nv_pkg::step_t    step
);

  logic              vld_r;
  logic              vld_nxt;
  utf8nv_pkg::item_t item_r;
  logic              advance;
  logic              accept;

  // A last beat may only move on when the result register has room
  assign advance  = vld_r && (!item_r.last_byte || out_free);
  assign in_ready = !vld_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign step.fire = advance;
  assign step.item = item_r;

endmodule

/* src/utf8nv_decode.sv */
// UTF-8 decode, per-name state and verdict logic, plus the max_len register.
// Depends on utf8nv_pkg.
module utf8nv_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [utf8nv_pkg::LEN_W-1:0]        cfg_wdata,
  input  utf8nv_pkg::step_t                   step,
  output utf8nv_pkg::verdict_t                verdict
);

  logic [1:0]                        pend_r, pend_nxt;
  logic [utf8nv_pkg::CP_W-1:0]       part_r, part_nxt;
  logic [utf8nv_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              enc_r, enc_nxt;
  logic                              chr_r, chr_nxt;
  logic [utf8nv_pkg::LEN_W-1:0]      max_len_r;

  logic [7:0]                        cur_byte;
  logic                              done;
  logic [utf8nv_pkg::CP_W-1:0]       point;
  logic                              enc_end;

  assign cur_byte = step.item.data_byte;

  // Byte decode and state update
  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    cnt_nxt  = cnt_r;
    enc_nxt  = enc_r;
    chr_nxt  = chr_r;
    done     = 1'b0;
    point    = '0;

    if (step.fire && step.item.byte_present) begin
      if (pend_r != 2'd0) begin
        if (cur_byte[7:6] != 2'b10) begin
          // broken sequence: drop it, byte is consumed
          enc_nxt  = 1'b1;
          pend_nxt = 2'd0;
          part_nxt = '0;
        end else begin
          part_nxt = {part_r[utf8nv_pkg::CP_W-7:0], cur_byte[5:0]};
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            done     = 1'b1;
            point    = part_nxt;
            part_nxt = '0;
          end
        end
      end else if (cur_byte[7] == 1'b0) begin
        done  = 1'b1;
        point = {13'd0, cur_byte};
      end else if (cur_byte[7:5] == 3'b110) begin
        part_nxt = {16'd0, cur_byte[4:0]};
        pend_nxt = 2'd1;
      end else if (cur_byte[7:4] == 4'b1110) begin
        part_nxt = {17'd0, cur_byte[3:0]};
        pend_nxt = 2'd2;
      end else if (cur_byte[7:3] == 5'b11110) begin
        part_nxt = {18'd0, cur_byte[2:0]};
        pend_nxt = 2'd3;
      end else begin
        // invalid lead, byte dropped
        enc_nxt = 1'b1;
      end
    end

    // Completed code point: saturating count, set check
    if (done) begin
      if (cnt_r != utf8nv_pkg::CNT_CAP) begin
        cnt_nxt = cnt_r + 7'd1;
      end
      if (!utf8nv_pkg::allowed_point(point)) begin
        chr_nxt = 1'b1;
      end
    end

    // Verdict, in priority order; truncated end counts as bad UTF-8
    enc_end = enc_nxt || (pend_nxt != 2'd0);
    verdict.load  = step.fire && step.item.last_byte;
    verdict.count = cnt_nxt;
    if (enc_end) begin
      verdict.status = utf8nv_pkg::ST_BAD_UTF8;
    end else if ((cnt_nxt == '0) || (cnt_nxt > {1'b0, max_len_r})) begin
      verdict.status = utf8nv_pkg::ST_BAD_LEN;
    end else if (chr_nxt) begin
      verdict.status = utf8nv_pkg::ST_BAD_CHAR;
    end else begin
      verdict.status = utf8nv_pkg::ST_OK;
    end

    // Clear for the next name
    if (verdict.load) begin
      pend_nxt = 2'd0;
      part_nxt = '0;
      cnt_nxt  = '0;
      enc_nxt  = 1'b0;
      chr_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 2'd0;
      part_r    <= '0;
      cnt_r     <= '0;
      enc_r     <= 1'b0;
      chr_r     <= 1'b0;
      max_len_r <= utf8nv_pkg::LEN_RST;
    end else begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
      enc_r  <= enc_nxt;
      chr_r  <= chr_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

endmodule

/* src/utf8nv_out_reg.sv */
// Result register: holds one verdict beat until the sink takes it.
// Depends on utf8nv_pkg.
module utf8nv_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  utf8nv_pkg::verdict_t            verdict,
  output logic                            out_free,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [utf8nv_pkg::CNT_W-1:0]    out_count
);

  logic                          vld_r, vld_nxt;
  utf8nv_pkg::status_t           status_r;
  logic [utf8nv_pkg::CNT_W-1:0]  count_r;

  assign out_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (verdict.load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (verdict.load) begin
      status_r <= verdict.status;
      count_r  <= verdict.count;
    end
  end

  assign out_valid  = vld_r;
  assign out_status = status_r;
  assign out_count  = count_r;

endmodule

/* src/utf8_name_validator.sv */
// Top level of the UTF-8 name validator: input register, decoder, result register.
// Depends on utf8nv_pkg, utf8nv_if and the utf8nv_* submodules.
//
//  channel   direction  beat
//  in_ch     sink       data_byte[7:0], byte_present, last_byte
//  out_ch    source     status[1:0], codepoint_count[6:0] (one per name)
//  cfg_*     write      max_len[5:0] on cfg_we
//
// One byte beat per cycle sustained while out_ch keeps taking verdicts; a beat is decoded
// from the input register, and each verdict waits in the result register for out_ch.
// The decode and range checks sit between the input and result registers.
// Reset (rst_n low, synchronous) clears name state and sets max_len to 32.
// A stalled out_ch only holds back the last beat of the next name.
module utf8_name_validator (
  input  logic                               clk,
  input  logic                               rst_n,
  utf8nv_in_if.sink                          in_ch,
  utf8nv_out_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [utf8nv_pkg::LEN_W-1:0]       cfg_wdata
);

  utf8nv_pkg::item_t    in_item;
  utf8nv_pkg::step_t    step;
  utf8nv_pkg::verdict_t verdict;
  logic                 out_free;

  assign in_item.data_byte    = in_ch.data_byte;
  assign in_item.byte_present = in_ch.byte_present;
  assign in_item.last_byte    = in_ch.last_byte;

  utf8nv_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .out_free (out_free),
    .step     (step)
  );

  utf8nv_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .verdict   (verdict)
  );

  utf8nv_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .verdict    (verdict),
    .out_free   (out_free),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_count  (out_ch.codepoint_count)
  );

endmodule

/* src/utf8nv_checker.sv */
// Port-level checks on the validator's result channel, bound to the top level.
// Depends on utf8nv_pkg and utf8_name_validator_assert.svh.
`include "utf8_name_validator_assert.svh"

module utf8nv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [6:0] out_count
);

  // Result beat holds while stalled
  `UTF8NV_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count), "result beat changed while stalled")

  // An accepted name has between one and 63 code points
  `UTF8NV_ASSERT(a_ok_count, clk, rst_n, out_valid && (out_status == utf8nv_pkg::ST_OK) |-> (out_count != 7'd0) && (out_count <= 7'd63), "ok verdict with impossible count")

  // Empty or saturated name with clean encoding must be a length fault
  `UTF8NV_ASSERT(a_len_fault, clk, rst_n, out_valid && (out_status != utf8nv_pkg::ST_BAD_UTF8) && ((out_count == 7'd0) || (out_count == 7'd64)) |-> out_status == utf8nv_pkg::ST_BAD_LEN, "length fault missed")

  // Count saturates at 64
  `UTF8NV_ASSERT(a_count_cap, clk, rst_n, out_valid |-> out_count <= 7'd64, "count above cap")

  // No result beat straight out of reset
  `UTF8NV_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind utf8_name_validator utf8nv_checker u_utf8nv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_count  (out_ch.codepoint_count)
);

/* dv/tb_utf8_name_validator.sv */
// Testbench for utf8_name_validator: walks a table of directed beats, then random
// names, and checks every verdict against a predictor. Needs utf8nv_pkg,
// utf8nv_if and the RTL of the block.
module tb_utf8_name_validator;

  localparam int CLK_PERIOD    = 8;
  localparam int TIMEOUT_CYC   = 400000;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_BEATS   = 250;
  localparam int MAX_PRINTS    = 40;

  typedef struct packed {
    utf8nv_pkg::status_t          status;
    logic [utf8nv_pkg::CNT_W-1:0] count;
  } name_verdict_t;

  // One directed beat; pin marks a verdict typed in by hand
  typedef struct packed {
    logic [7:0]                   b;
    logic                         p;
    logic                         l;
    logic                         pin;
    utf8nv_pkg::status_t          st;
    logic [utf8nv_pkg::CNT_W-1:0] cnt;
  } stim_row_t;

  typedef enum int {SHAPE_CLEAN, SHAPE_BROKEN, SHAPE_NOISE} name_shape_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_CHOKED} sink_mode_t;

  localparam name_verdict_t NO_PIN = '{utf8nv_pkg::ST_OK, 7'd0};

  // Allowed code points as inclusive ranges; the first five are ASCII
  localparam logic [utf8nv_pkg::CP_W-1:0] SET_LO [10] = '{21'h30, 21'h41, 21'h61,
    21'h5F, 21'h2D, 21'h3400, 21'h4E00, 21'hF900, 21'h20000, 21'h2A700};
  localparam logic [utf8nv_pkg::CP_W-1:0] SET_HI [10] = '{21'h39, 21'h5A, 21'h7A,
    21'h5F, 21'h2D, 21'h4DBF, 21'h9FFF, 21'hFAFF, 21'h2A6DF, 21'h2CEAF};

  localparam stim_row_t DIRECTED [22] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, utf8nv_pkg::ST_BAD_LEN,  7'd0},  // empty name
    '{8'h61, 1'b1, 1'b1, 1'b1, utf8nv_pkg::ST_OK,       7'd1},  // 'a'
    '{8'h00, 1'b1, 1'b1, 1'b1, utf8nv_pkg::ST_BAD_CHAR, 7'd1},  // NUL
    '{8'hFF, 1'b1, 1'b1, 1'b1, utf8nv_pkg::ST_BAD_UTF8, 7'd0},  // invalid lead
    '{8'h80, 1'b1, 1'b1, 1'b1, utf8nv_pkg::ST_BAD_UTF8, 7'd0},  // stray continuation
    '{8'hAA, 1'b0, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},  // no byte, not last
    '{8'h2D, 1'b1, 1'b1, 1'b1, utf8nv_pkg::ST_OK,       7'd1},  // '-'
    '{8'hC3, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},  // two-byte, outside set
    '{8'hA9, 1'b1, 1'b1, 1'b0, utf8nv_pkg::ST_OK,       7'd0},
    '{8'hE4, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},  // three-byte CJK
    '{8'hB8, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},
    '{8'h80, 1'b1, 1'b1, 1'b0, utf8nv_pkg::ST_OK,       7'd0},
    '{8'hF0, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},  // four-byte CJK ext
    '{8'hA0, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},
    '{8'h80, 1'b1, 1'b1, 1'b0, utf8nv_pkg::ST_OK,       7'd0},
    '{8'hC3, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},  // missing continuation
    '{8'h41, 1'b1, 1'b1, 1'b1, utf8nv_pkg::ST_BAD_UTF8, 7'd0},
    '{8'hE4, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},  // truncated at the end
    '{8'hB8, 1'b1, 1'b1, 1'b1, utf8nv_pkg::ST_BAD_UTF8, 7'd0},
    '{8'h35, 1'b1, 1'b0, 1'b0, utf8nv_pkg::ST_OK,       7'd0},  // closed by bare end beat
    '{8'h00, 1'b0, 1'b1, 1'b0, utf8nv_pkg::ST_OK,       7'd0}
  };

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [utf8nv_pkg::LEN_W-1:0] cfg_wdata;

  utf8nv_in_if  in_ch ();
  utf8nv_out_if out_ch ();

  utf8_name_validator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // Predictor state
  logic [utf8nv_pkg::LEN_W-1:0] max_len_reg;
  logic [1:0]                   pend_cont;
  logic [utf8nv_pkg::CP_W-1:0]  part_point;
  logic [utf8nv_pkg::CNT_W-1:0] point_tally;
  bit                           utf8_broken;
  bit                           char_outside;

  name_verdict_t verdict_q [$];
  logic [7:0]    name_bytes [$];
  int            errors = 0;
  int            results_seen = 0;
  int            beats_sent = 0;
  int            burst_left = 0;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic bit in_name_set(input logic [utf8nv_pkg::CP_W-1:0] c);
    for (int k = 0; k < 10; k++)
      if (c >= SET_LO[k] && c <= SET_HI[k]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_tally();
    pend_cont    = 2'd0;
    part_point   = '0;
    point_tally  = '0;
    utf8_broken  = 1'b0;
    char_outside = 1'b0;
  endfunction

  function automatic void close_point(input logic [utf8nv_pkg::CP_W-1:0] c);
    if (point_tally < utf8nv_pkg::CNT_CAP) point_tally = point_tally + 1'b1;
    if (!in_name_set(c)) char_outside = 1'b1;
  endfunction

  // Append one byte to the name being built
  function automatic void add_byte(input logic [7:0] b);
    name_bytes.insert(name_bytes.size(), b);
  endfunction

  // Decode one accepted beat; gives a verdict on the last beat of a name
  task automatic judge_beat(input logic [7:0] b, input logic p, input logic l,
                            output bit has_v, output name_verdict_t v);
    has_v = 1'b0;
    v = NO_PIN;
    if (p) begin
      if (pend_cont != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          utf8_broken = 1'b1;
          pend_cont   = 2'd0;
          part_point  = '0;
        end else begin
          part_point = {part_point[14:0], b[5:0]};
          pend_cont  = pend_cont - 2'd1;
          if (pend_cont == 2'd0) begin
            close_point(part_point);
            part_point = '0;
          end
        end
      end else if (!b[7]) begin
        close_point({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
        part_point = {16'd0, b[4:0]};
        pend_cont  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        part_point = {17'd0, b[3:0]};
        pend_cont  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        part_point = {18'd0, b[2:0]};
        pend_cont  = 2'd3;
      end else begin
        utf8_broken = 1'b1;
      end
    end
    if (l) begin
      if (pend_cont != 2'd0) utf8_broken = 1'b1;
      if (utf8_broken) v.status = utf8nv_pkg::ST_BAD_UTF8;
      else if (point_tally == '0 || point_tally > {1'b0, max_len_reg})
        v.status = utf8nv_pkg::ST_BAD_LEN;
      else if (char_outside) v.status = utf8nv_pkg::ST_BAD_CHAR;
      else v.status = utf8nv_pkg::ST_OK;
      v.count = point_tally;
      has_v = 1'b1;
      clear_tally();
    end
  endtask

  // Offer one beat from a falling edge; returns on the falling edge after acceptance
  task automatic send_beat(input logic [7:0] b, input logic p, input logic l,
                           input bit pinned, input name_verdict_t pin_v);
    bit            has_v;
    name_verdict_t v;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid        = 1'b1;
    in_ch.data_byte    = b;
    in_ch.byte_present = p;
    in_ch.last_byte    = l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    judge_beat(b, p, l, has_v, v);
    if (has_v) verdict_q.insert(verdict_q.size(), pinned ? pin_v : v);
    @(negedge clk);
  endtask

  // Write max_len once everything in flight has drained
  task automatic set_max_len(input logic [utf8nv_pkg::LEN_W-1:0] val);
    in_ch.valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = val;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we      = 1'b0;
    max_len_reg = val;
  endtask

  // Build one random name and send it
  task automatic send_name();
    name_shape_t shape;
    int          r, npts, fault_pos, n, k, maxl;
    bit          marker_end;
    logic [utf8nv_pkg::CP_W-1:0] cp;
    name_bytes.delete();
    maxl = max_len_reg;
    r = $urandom_range(0, 99);
    shape = (r < 70) ? SHAPE_CLEAN : (r < 88) ? SHAPE_BROKEN : SHAPE_NOISE;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: npts = $urandom_range(0, 6);
      4, 5, 6, 7: npts = $urandom_range((maxl > 2) ? maxl - 2 : 0, maxl + 2);
      8:          npts = $urandom_range(62, 70);
      default:    npts = $urandom_range(0, 20);
    endcase
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
    end else begin
      fault_pos = (shape == SHAPE_BROKEN) ? $urandom_range(0, npts) : -1;
      for (int i = 0; i <= npts; i++) begin
        // broken sequence: bad lead, or a lead short of its continuations
        if (i == fault_pos) begin
          if ($urandom_range(0, 2) == 0) begin
            add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'hF8, 8'hFF))
                                          : 8'($urandom_range(8'h80, 8'hBF)));
          end else begin
            n = $urandom_range(2, 4);
            k = $urandom_range(0, n - 2);
            case (n)
              2:       add_byte({3'b110, 5'($urandom)});
              3:       add_byte({4'b1110, 4'($urandom)});
              default: add_byte({5'b11110, 3'($urandom)});
            endcase
            repeat (k) add_byte({2'b10, 6'($urandom)});
          end
        end
        if (i < npts) begin
          if ($urandom_range(0, 9) < 8) begin
            k  = $urandom_range(0, 9);
            cp = utf8nv_pkg::CP_W'($urandom_range(SET_LO[k], SET_HI[k]));
            n  = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            // overlong forms are legal here
            if (n < 4 && $urandom_range(0, 9) == 0) n++;
          end else begin
            n = $urandom_range(1, 4);
            case (n)
              1:       cp = utf8nv_pkg::CP_W'($urandom) & 21'h7F;
              2:       cp = utf8nv_pkg::CP_W'($urandom) & 21'h7FF;
              3:       cp = utf8nv_pkg::CP_W'($urandom) & 21'hFFFF;
              default: cp = utf8nv_pkg::CP_W'($urandom);
            endcase
          end
          case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
              add_byte({3'b110, cp[10:6]});
              add_byte({2'b10, cp[5:0]});
            end
            3: begin
              add_byte({4'b1110, cp[15:12]});
              add_byte({2'b10, cp[11:6]});
              add_byte({2'b10, cp[5:0]});
            end
            default: begin
              add_byte({5'b11110, cp[20:18]});
              add_byte({2'b10, cp[17:12]});
              add_byte({2'b10, cp[11:6]});
              add_byte({2'b10, cp[5:0]});
            end
          endcase
        end
      end
    end
    marker_end = (name_bytes.size() == 0) || ($urandom_range(0, 9) == 0);
    foreach (name_bytes[j]) begin
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, NO_PIN);
      send_beat(name_bytes[j], 1'b1, (j == name_bytes.size() - 1) && !marker_end,
                1'b0, NO_PIN);
    end
    if (marker_end) send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, NO_PIN);
  endtask

  // Result checker
  always @(posedge clk) begin
    name_verdict_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict with none pending: status %0d count %0d",
                                  out_ch.status, out_ch.codepoint_count));
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_ch.status !== exp_v.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_ch.status, exp_v.status));
        if (out_ch.codepoint_count !== exp_v.count)
          report_mismatch($sformatf("codepoint_count %0d, expected %0d",
                                    out_ch.codepoint_count, exp_v.count));
      end
    end
  end

  // Receiver: stall patterns in stretches, plus one long hold-off
  initial begin : result_sink
    sink_mode_t mode;
    int         span, tick;
    bit         held_off;
    out_ch.ready = 1'b0;
    held_off = 1'b0;
    tick = 0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (!held_off && results_seen >= 30) begin
          held_off = 1'b1;
          out_ch.ready = 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
        end
        case (mode)
          SINK_OPEN:   out_ch.ready = 1'b1;
          SINK_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
          SINK_COMB:   out_ch.ready = (tick % 5) != 0;
          SINK_CHOKED: out_ch.ready = ($urandom_range(0, 3) == 0);
          default:     out_ch.ready = 1'b1;
        endcase
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int                           budget;
    logic [utf8nv_pkg::LEN_W-1:0] plen;
    name_verdict_t                pin_v;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.byte_present = 1'b0;
    in_ch.last_byte    = 1'b0;
    max_len_reg        = utf8nv_pkg::LEN_RST;
    clear_tally();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed beats at the reset setting
    foreach (DIRECTED[i]) begin
      pin_v = '{DIRECTED[i].st, DIRECTED[i].cnt};
      send_beat(DIRECTED[i].b, DIRECTED[i].p, DIRECTED[i].l, DIRECTED[i].pin, pin_v);
    end

    // random names over several max_len settings, extremes first
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       plen = 6'd63;
        1:       plen = 6'd1;
        2:       plen = 6'd0;
        3:       plen = 6'd5;
        default: plen = utf8nv_pkg::LEN_W'($urandom_range(2, 62));
      endcase
      set_max_len(plen);
      budget = beats_sent + PHASE_BEATS;
      while (beats_sent < budget) send_name();
    end

    in_ch.valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_name_validator verification clean");
    end else begin
      $display("utf8_name_validator verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_CYC * CLK_PERIOD);
    $display("utf8_name_validator verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/utf8nv_pkg.sv
src/utf8nv_if.sv
src/utf8nv_in_reg.sv
src/utf8nv_decode.sv
src/utf8nv_out_reg.sv
src/utf8_name_validator.sv
src/utf8nv_checker.sv
dv/tb_utf8_name_validator.sv
